/* hdl/mvt_pkg.sv */
// mvt_pkg: shared types and constants of the matrix vector transform.
// Used by mvt_mac, mvt_div and matrix_vector_transform; depends on nothing.
package mvt_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_PAIRS      = 8;
    localparam int PAIR_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH  = 4;
    localparam int FIELD_WIDTH    = 32;

    typedef enum logic [1:0] {
        REQ_NORMAL = 2'd0,
        REQ_POINT  = 2'd1,
        REQ_DIVIDE = 2'd2,
        REQ_VEC4   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        DIV_PASS = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_ZERO = 2'd2
    } t_div_kind;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
        logic [31:0] in_w;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
        logic        w_zero;
        logic        saturated;
    } t_out_item;

    // Side data that travels alongside the divider lanes
    typedef struct packed {
        logic        valid;
        logic        wz;
        logic        sat;
        logic [31:0] w;
    } t_side;

endpackage

/* hdl/mvt_mac.sv */
// mvt_mac: input register, sixteen products and four saturated row sums.
// Depends on mvt_pkg.
module mvt_mac #(
    parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  mvt_pkg::t_req_type                           i_mode,
    input  logic [3:0][DATA_WIDTH-1:0]                   i_v,
    input  logic [mvt_pkg::NUM_PAIRS-1:0][mvt_pkg::PAIR_WIDTH-1:0] i_pairs,
    output logic                                         o_valid,
    output mvt_pkg::t_req_type                           o_mode,
    output logic [3:0][DATA_WIDTH-1:0]                   o_r,
    output logic                                         o_sat
);
    localparam int PW = 2 * DATA_WIDTH - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] MAX_S = SW'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
    localparam logic signed [SW-1:0] MIN_S = -MAX_S - SW'(1);

    // Exact product, then floor shift by the fraction bits
    function automatic logic signed [PW-1:0] mul_shift(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [2*DATA_WIDTH-1:0] p;
        p = a * b;
        return PW'(p >>> FRAC_BITS);
    endfunction

    logic                     r_va, r_vb, r_vc;
    mvt_pkg::t_req_type       r_ma, r_mb, r_mc;
    logic [3:0][DATA_WIDTH-1:0] r_v;
    logic [15:0][PW-1:0]      r_p;
    logic [3:0][DATA_WIDTH-1:0] r_r;
    logic                     r_sat;
    logic [15:0][DATA_WIDTH-1:0] w_e;
    logic [3:0][DATA_WIDTH-1:0] n_r;
    logic                     n_sat;

    // Split the register pairs into elements
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_e[i] = i_pairs[i / 2][(i % 2) * 32 +: DATA_WIDTH];
        end
    end

    // Control valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Stage A: hold the vector with w chosen by mode
    always_ff @(posedge i_clk) begin
        r_ma <= i_mode;
        r_v[0] <= i_v[0];
        r_v[1] <= i_v[1];
        r_v[2] <= i_v[2];
        case (i_mode)
            mvt_pkg::REQ_NORMAL: r_v[3] <= '0;
            mvt_pkg::REQ_VEC4:   r_v[3] <= i_v[3];
            default:             r_v[3] <= DATA_WIDTH'(64'(1) << FRAC_BITS);
        endcase
    end

    // Stage B: sixteen products
    always_ff @(posedge i_clk) begin
        r_mb <= r_ma;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                r_p[4 * c + r] <= mul_shift($signed(r_v[c]), $signed(w_e[4 * c + r]));
            end
        end
    end

    // Stage C: sum each row and clamp
    always_comb begin
        logic signed [SW-1:0] s;
        n_sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            s = SW'($signed(r_p[r])) + SW'($signed(r_p[4 + r]))
              + SW'($signed(r_p[8 + r])) + SW'($signed(r_p[12 + r]));
            if (s > MAX_S) begin
                n_r[r] = DATA_WIDTH'(MAX_S);
                if (r < 3 || r_mb != mvt_pkg::REQ_NORMAL) n_sat = 1'b1;
            end else if (s < MIN_S) begin
                n_r[r] = DATA_WIDTH'(MIN_S);
                if (r < 3 || r_mb != mvt_pkg::REQ_NORMAL) n_sat = 1'b1;
            end else begin
                n_r[r] = DATA_WIDTH'(s);
            end
        end
        if (r_mb == mvt_pkg::REQ_NORMAL) n_r[3] = '0;
    end

    always_ff @(posedge i_clk) begin
        r_mc  <= r_mb;
        r_r   <= n_r;
        r_sat <= n_sat;
    end

    assign o_valid = r_vc;
    assign o_mode  = r_mc;
    assign o_r     = r_r;
    assign o_sat   = r_sat;

endmodule

/* hdl/mvt_div.sv */
// mvt_div: one divider lane, one quotient bit per pipeline stage, with clamp.
// Depends on mvt_pkg.
module mvt_div #(
    parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_div,
    input  logic [DATA_WIDTH-1:0] i_n,
    input  logic [DATA_WIDTH-1:0] i_w,
    output logic [DATA_WIDTH-1:0] o_q,
    output logic                  o_sat
);
    localparam int NSTEP = DATA_WIDTH + FRAC_BITS;
    localparam logic [NSTEP-1:0] MAX_Q = NSTEP'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
    localparam logic [DATA_WIDTH-1:0] MAX_D = DATA_WIDTH'(MAX_Q);
    localparam logic [DATA_WIDTH-1:0] MIN_D = ~MAX_D;

    mvt_pkg::t_div_kind      r_kind [NSTEP+1];
    logic                    r_neg  [NSTEP+1];
    logic [DATA_WIDTH-1:0]   r_n    [NSTEP+1];
    logic [DATA_WIDTH-1:0]   r_aw   [NSTEP+1];
    logic [DATA_WIDTH-1:0]   r_rem  [NSTEP+1];
    logic [NSTEP-1:0]        r_q    [NSTEP+1];
    logic [NSTEP-1:0]        r_dvd  [NSTEP+1];
    logic [DATA_WIDTH-1:0]   r_out;
    logic                    r_sat;
    logic [DATA_WIDTH-1:0]   w_an;

    assign w_an = i_n[DATA_WIDTH-1] ? (~i_n + DATA_WIDTH'(1)) : i_n;

    // Prepare magnitudes and pick the kind of work
    always_ff @(posedge i_clk) begin
        r_neg[0] <= i_n[DATA_WIDTH-1] ^ i_w[DATA_WIDTH-1];
        r_n[0]   <= i_n;
        r_aw[0]  <= i_w[DATA_WIDTH-1] ? (~i_w + DATA_WIDTH'(1)) : i_w;
        r_rem[0] <= '0;
        r_q[0]   <= '0;
        r_dvd[0] <= {w_an, {FRAC_BITS{1'b0}}};
        if (!i_div) r_kind[0] <= mvt_pkg::DIV_PASS;
        else if (i_w == '0) r_kind[0] <= mvt_pkg::DIV_ZERO;
        else r_kind[0] <= mvt_pkg::DIV_RUN;
    end

    // Restoring steps, one quotient bit each
    for (genvar s = 1; s <= NSTEP; s++) begin : g_step
        logic [DATA_WIDTH:0] w_trial;
        logic                w_ge;
        assign w_trial = {r_rem[s-1], r_dvd[s-1][NSTEP-1]};
        assign w_ge    = w_trial >= {1'b0, r_aw[s-1]};
        always_ff @(posedge i_clk) begin
            r_kind[s] <= r_kind[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_n[s]    <= r_n[s-1];
            r_aw[s]   <= r_aw[s-1];
            r_dvd[s]  <= r_dvd[s-1] << 1;
            r_q[s]    <= {r_q[s-1][NSTEP-2:0], w_ge};
            r_rem[s]  <= w_ge ? DATA_WIDTH'(w_trial - {1'b0, r_aw[s-1]})
                              : w_trial[DATA_WIDTH-1:0];
        end
    end

    // Apply sign and clamp the quotient; on zero w clamp to the numerator's sign, else pass n through
    always_ff @(posedge i_clk) begin
        case (r_kind[NSTEP])
            mvt_pkg::DIV_RUN: begin
                if (!r_neg[NSTEP]) begin
                    r_sat <= r_q[NSTEP] > MAX_Q;
                    r_out <= (r_q[NSTEP] > MAX_Q) ? MAX_D : r_q[NSTEP][DATA_WIDTH-1:0];
                end else begin
                    r_sat <= r_q[NSTEP] > MAX_Q + NSTEP'(1);
                    r_out <= (r_q[NSTEP] > MAX_Q + NSTEP'(1)) ? MIN_D
                           : DATA_WIDTH'(~r_q[NSTEP] + NSTEP'(1));
                end
            end
            mvt_pkg::DIV_ZERO: begin
                r_sat <= r_n[NSTEP] != '0;
                if (r_n[NSTEP] == '0) r_out <= '0;
                else if (r_n[NSTEP][DATA_WIDTH-1]) r_out <= MIN_D;
                else r_out <= MAX_D;
            end
            default: begin
                r_sat <= 1'b0;
                r_out <= r_n[NSTEP];
            end
        endcase
    end

    assign o_q   = r_out;
    assign o_sat = r_sat;

endmodule

/* hdl/matrix_vector_transform.sv */
// matrix_vector_transform: top level, matrix registers, lanes and output register.
// Depends on mvt_pkg, mvt_mac and mvt_div.
//
// Takes one vector per clock whenever i_start is high (o_busy stays low) and
// returns one result per vector, in order, through the multiply stages, the
// divider lanes and the output register, marked by a one-cycle o_valid. Most
// of the pipeline is the divider, which resolves one quotient bit per stage;
// all items, not only perspective-divide items, go through it. The receiver
// cannot stall the block. Write the matrix only while no item is in flight.
module matrix_vector_transform #(
    parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  mvt_pkg::t_in_item                     i_item,
    input  logic                                  i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [mvt_pkg::PAIR_WIDTH-1:0]        i_cfg_data,
    output logic                                  o_valid,
    output mvt_pkg::t_out_item                    o_result
);
    localparam int DIV_LAT = DATA_WIDTH + FRAC_BITS + 2;
    localparam int LAT     = DIV_LAT + 4;
    localparam logic [mvt_pkg::PAIR_WIDTH-1:0] ONE_LO = mvt_pkg::PAIR_WIDTH'(64'(1) << FRAC_BITS);
    localparam logic [mvt_pkg::PAIR_WIDTH-1:0] ONE_HI = ONE_LO << 32;
    localparam logic [mvt_pkg::PAIR_WIDTH-1:0] ZERO_P = '0;
    localparam logic [mvt_pkg::NUM_PAIRS-1:0][mvt_pkg::PAIR_WIDTH-1:0] RST_PAIRS =
        {ONE_HI, ZERO_P, ONE_LO, ZERO_P, ZERO_P, ONE_HI, ZERO_P, ONE_LO};

    logic [mvt_pkg::NUM_PAIRS-1:0][mvt_pkg::PAIR_WIDTH-1:0] r_pairs;
    logic [3:0][DATA_WIDTH-1:0] w_v;
    logic [3:0][DATA_WIDTH-1:0] w_r;
    logic [2:0][DATA_WIDTH-1:0] w_q;
    logic [2:0]                 w_qsat;
    logic                       w_mvalid;
    logic                       w_msat;
    logic                       w_div;
    mvt_pkg::t_req_type         w_mode;
    mvt_pkg::t_side             r_side [DIV_LAT];
    logic                       r_valid;
    mvt_pkg::t_out_item         r_result;

    assign o_busy = 1'b0;

    // Matrix registers, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= RST_PAIRS;
        end else if (i_cfg_we && i_cfg_idx < mvt_pkg::CFG_IDX_WIDTH'(mvt_pkg::NUM_PAIRS)) begin
            r_pairs[i_cfg_idx[$clog2(mvt_pkg::NUM_PAIRS)-1:0]] <= i_cfg_data;
        end
    end

    assign w_v[0] = i_item.in_x[DATA_WIDTH-1:0];
    assign w_v[1] = i_item.in_y[DATA_WIDTH-1:0];
    assign w_v[2] = i_item.in_z[DATA_WIDTH-1:0];
    assign w_v[3] = i_item.in_w[DATA_WIDTH-1:0];

    mvt_mac #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_mode  (mvt_pkg::t_req_type'(i_item.req_type)),
        .i_v     (w_v),
        .i_pairs (r_pairs),
        .o_valid (w_mvalid),
        .o_mode  (w_mode),
        .o_r     (w_r),
        .o_sat   (w_msat)
    );

    assign w_div = w_mode == mvt_pkg::REQ_DIVIDE;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        mvt_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div (
            .i_clk (i_clk),
            .i_div (w_div),
            .i_n   (w_r[k]),
            .i_w   (w_r[3]),
            .o_q   (w_q[k]),
            .o_sat (w_qsat[k])
        );
    end

    // Delay w and flags alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_side[i].valid <= 1'b0;
        end else begin
            r_side[0].valid <= w_mvalid;
            for (int i = 1; i < DIV_LAT; i++) r_side[i].valid <= r_side[i-1].valid;
        end
        r_side[0].wz  <= w_div && w_r[3] == '0;
        r_side[0].sat <= w_msat;
        r_side[0].w   <= 32'($signed(w_r[3]));
        for (int i = 1; i < DIV_LAT; i++) begin
            r_side[i].wz  <= r_side[i-1].wz;
            r_side[i].sat <= r_side[i-1].sat;
            r_side[i].w   <= r_side[i-1].w;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_side[DIV_LAT-1].valid;
        end
        r_result.out_x     <= 32'($signed(w_q[0]));
        r_result.out_y     <= 32'($signed(w_q[1]));
        r_result.out_z     <= 32'($signed(w_q[2]));
        r_result.out_w     <= r_side[DIV_LAT-1].w;
        r_result.w_zero    <= r_side[DIV_LAT-1].wz;
        r_result.saturated <= r_side[DIV_LAT-1].sat || (|w_qsat);
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Every result must have an item behind it, taken in at i_start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without an item at the expected latency");

    // A zero w flag comes with a zero w
    a_wz_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.w_zero |-> o_result.out_w == 32'd0)
        else $error("w_zero with nonzero w");

    // Clamping the x component on zero w must raise the saturation flag
    a_wz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.w_zero && o_result.out_x != 32'd0 |-> o_result.saturated)
        else $error("zero-w clamp without saturation flag");

endmodule
